FILE: rtl/hough_line_vote_accumulator_top_defines.svh
// ----------------------------------------------------------------------------
// Hough line vote accumulator assertion macros
// Shared concurrent assertion forms for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_TOP_DEFINES_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define HLVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define HLVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/hlva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough line vote accumulator package
// Types, codes and the sine table shared by the accumulator modules.
// ----------------------------------------------------------------------------
package hlva_pkg;

  localparam int unsigned ANGLE_BINS  = 180;
  localparam int unsigned IDX_W       = 19;
  localparam int unsigned MAG_W       = 40;
  localparam int unsigned XS_W        = 31;
  localparam int unsigned PR_W        = 52;
  localparam int unsigned RECIP_SHIFT = 41;

  localparam logic [1:0] KIND_VOTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic CFG_HALF_RADIUS = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  localparam logic [20:0] RND_DIV   = 21'd1953125;
  localparam logic [20:0] RND_RECIP = 21'd1125899;
  localparam logic [39:0] HALF_UNIT = 40'd500000000;

  typedef enum logic [1:0] {OP_NONE, OP_VOTE, OP_READ, OP_CLEAR} op_e;

  typedef struct packed {
    op_e        op;
    logic [9:0] a;
    logic [9:0] b;
    logic [7:0] angle;
    logic [9:0] radius;
    logic       read_ok;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic init;
    logic pop;
  } bk_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] k;
  } rad_req_t;

  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic [IDX_W-1:0] idx;
  } rad_rsp_t;

  // sin(i degrees) in units of 1e-9, i = 0..90.
  function automatic logic [29:0] sin_tab(input logic [6:0] i);
    logic [29:0] v;
    case (i)
      7'd0:  v = 30'd0;         7'd1:  v = 30'd17452406;  7'd2:  v = 30'd34899497;
      7'd3:  v = 30'd52335956;  7'd4:  v = 30'd69756474;  7'd5:  v = 30'd87155743;
      7'd6:  v = 30'd104528463; 7'd7:  v = 30'd121869343; 7'd8:  v = 30'd139173101;
      7'd9:  v = 30'd156434465; 7'd10: v = 30'd173648178; 7'd11: v = 30'd190808995;
      7'd12: v = 30'd207911691; 7'd13: v = 30'd224951054; 7'd14: v = 30'd241921896;
      7'd15: v = 30'd258819045; 7'd16: v = 30'd275637356; 7'd17: v = 30'd292371705;
      7'd18: v = 30'd309016994; 7'd19: v = 30'd325568154; 7'd20: v = 30'd342020143;
      7'd21: v = 30'd358367950; 7'd22: v = 30'd374606593; 7'd23: v = 30'd390731128;
      7'd24: v = 30'd406736643; 7'd25: v = 30'd422618262; 7'd26: v = 30'd438371147;
      7'd27: v = 30'd453990500; 7'd28: v = 30'd469471563; 7'd29: v = 30'd484809620;
      7'd30: v = 30'd500000000; 7'd31: v = 30'd515038075; 7'd32: v = 30'd529919264;
      7'd33: v = 30'd544639035; 7'd34: v = 30'd559192903; 7'd35: v = 30'd573576436;
      7'd36: v = 30'd587785252; 7'd37: v = 30'd601815023; 7'd38: v = 30'd615661475;
      7'd39: v = 30'd629320391; 7'd40: v = 30'd642787610; 7'd41: v = 30'd656059029;
      7'd42: v = 30'd669130606; 7'd43: v = 30'd681998360; 7'd44: v = 30'd694658370;
      7'd45: v = 30'd707106781; 7'd46: v = 30'd719339800; 7'd47: v = 30'd731353702;
      7'd48: v = 30'd743144825; 7'd49: v = 30'd754709580; 7'd50: v = 30'd766044443;
      7'd51: v = 30'd777145961; 7'd52: v = 30'd788010754; 7'd53: v = 30'd798635510;
      7'd54: v = 30'd809016994; 7'd55: v = 30'd819152044; 7'd56: v = 30'd829037573;
      7'd57: v = 30'd838670568; 7'd58: v = 30'd848048096; 7'd59: v = 30'd857167301;
      7'd60: v = 30'd866025404; 7'd61: v = 30'd874619707; 7'd62: v = 30'd882947593;
      7'd63: v = 30'd891006524; 7'd64: v = 30'd898794046; 7'd65: v = 30'd906307787;
      7'd66: v = 30'd913545458; 7'd67: v = 30'd920504853; 7'd68: v = 30'd927183855;
      7'd69: v = 30'd933580426; 7'd70: v = 30'd939692621; 7'd71: v = 30'd945518576;
      7'd72: v = 30'd951056516; 7'd73: v = 30'd956304756; 7'd74: v = 30'd961261696;
      7'd75: v = 30'd965925826; 7'd76: v = 30'd970295726; 7'd77: v = 30'd974370065;
      7'd78: v = 30'd978147601; 7'd79: v = 30'd981627183; 7'd80: v = 30'd984807753;
      7'd81: v = 30'd987688341; 7'd82: v = 30'd990268069; 7'd83: v = 30'd992546152;
      7'd84: v = 30'd994521895; 7'd85: v = 30'd996194698; 7'd86: v = 30'd997564050;
      7'd87: v = 30'd998629535; 7'd88: v = 30'd999390827; 7'd89: v = 30'd999847695;
      7'd90: v = 30'd1000000000;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/hlva_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough accumulator front end
// Accepts input transfers, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module hlva_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [8:0]          row_i,
  input  logic [8:0]          column_i,
  input  logic                edge_req_i,
  input  logic [7:0]          angle_bin_i,
  input  logic [9:0]          radius_bin_i,
  input  logic [9:0]          h_i,
  input  hlva_pkg::bk_stat_t  stat_i,
  output hlva_pkg::q_head_t   head_o
);

  hlva_pkg::item_t ent_q [2];
  hlva_pkg::item_t cls;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  always_comb begin
    cls.a       = 10'({1'b0, row_i}) + 10'd1;
    cls.b       = 10'({1'b0, column_i}) + 10'd1;
    cls.angle   = angle_bin_i;
    cls.radius  = radius_bin_i;
    cls.read_ok = (angle_bin_i < 8'(hlva_pkg::ANGLE_BINS))
                  && ({1'b0, radius_bin_i} < {h_i, 1'b0});
    case (kind_i)
      hlva_pkg::KIND_VOTE:  cls.op = edge_req_i ? hlva_pkg::OP_VOTE : hlva_pkg::OP_NONE;
      hlva_pkg::KIND_READ:  cls.op = hlva_pkg::OP_READ;
      hlva_pkg::KIND_CLEAR: cls.op = hlva_pkg::OP_CLEAR;
      default:              cls.op = hlva_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2) && !stat_i.init;
  assign push         = in_valid_i && in_ready_o;
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.item  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, stat_i.pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/hlva_radius.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough accumulator cell index pipeline
// Turns a pixel and an angle bin into a rounded radius and a cell index.
// ----------------------------------------------------------------------------
module hlva_radius (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hlva_pkg::rad_req_t  req_i,
  input  logic [9:0]          a_i,
  input  logic [9:0]          b_i,
  input  logic [9:0]          h_i,
  output hlva_pkg::rad_rsp_t  rsp_o
);

  localparam int unsigned IW = hlva_pkg::IDX_W;

  logic [8:0]  v_q;
  logic [7:1]  k0_q;
  logic [7:0]  k1_q;
  logic        aneg1_q, aneg2_q;
  logic [29:0] ub1_q, ua1_q;
  logic [hlva_pkg::MAG_W-1:0] pb2_q, pa2_q, pos3_q, neg3_q, mag4_q;
  logic [IW-1:0] base_q [2:8];
  logic [5:8]  posv_q;
  logic [hlva_pkg::XS_W-1:0] xs5_q, xs6_q, xs7_q;
  logic [hlva_pkg::PR_W-1:0] pr6_q;
  logic [10:0] qe7_q;
  logic [31:0] qd7_q;
  logic [10:0] r8_q;
  logic [IW-1:0] idx9_q, limit_q;
  logic        lt90;
  logic [6:0]  ib, ia;
  logic [31:0] rem7;
  logic [10:0] q7;

  always_comb begin
    lt90 = req_i.k <= 8'd90;
    ib   = lt90 ? req_i.k[6:0] : 7'(8'd180 - req_i.k);
    ia   = lt90 ? 7'(8'd90 - req_i.k) : 7'(req_i.k - 8'd90);
    rem7 = {1'b0, xs7_q} - qd7_q;
    q7   = qe7_q + ((rem7 >= 32'(hlva_pkg::RND_DIV)) ? 11'd1 : 11'd0);
  end

  always_ff @(posedge clk_i) begin
    limit_q   <= IW'(hlva_pkg::ANGLE_BINS) * IW'({h_i, 1'b0});
    k1_q      <= req_i.k;
    k0_q[1]   <= req_i.k == 8'd0;
    aneg1_q   <= !lt90;
    ub1_q     <= hlva_pkg::sin_tab(ib);
    ua1_q     <= hlva_pkg::sin_tab(ia);
    pb2_q     <= hlva_pkg::MAG_W'(b_i) * hlva_pkg::MAG_W'(ub1_q);
    pa2_q     <= hlva_pkg::MAG_W'(a_i) * hlva_pkg::MAG_W'(ua1_q);
    base_q[2] <= IW'(k1_q) * IW'({h_i, 1'b0});
    aneg2_q   <= aneg1_q;
    pos3_q    <= aneg2_q ? pb2_q : pb2_q + pa2_q;
    neg3_q    <= aneg2_q ? pa2_q : '0;
    mag4_q    <= (pos3_q >= neg3_q) ? pos3_q - neg3_q : neg3_q - pos3_q;
    posv_q[5] <= pos3_q > neg3_q;
    xs5_q     <= hlva_pkg::XS_W'((mag4_q + hlva_pkg::HALF_UNIT) >> 9);
    pr6_q     <= hlva_pkg::PR_W'(xs5_q) * hlva_pkg::PR_W'(hlva_pkg::RND_RECIP);
    xs6_q     <= xs5_q;
    qe7_q     <= pr6_q[hlva_pkg::PR_W-1:hlva_pkg::RECIP_SHIFT];
    qd7_q     <= 32'(pr6_q[hlva_pkg::PR_W-1:hlva_pkg::RECIP_SHIFT])
                 * 32'(hlva_pkg::RND_DIV);
    xs7_q     <= xs6_q;
    r8_q      <= k0_q[7] ? 11'(a_i) : q7 + (posv_q[8] ? 11'(h_i) : 11'd0);
    idx9_q    <= base_q[8] + IW'(r8_q);
    for (int s = 2; s < 8; s++) begin
      base_q[s+1] <= base_q[s];
    end
    for (int s = 5; s < 8; s++) begin
      posv_q[s+1] <= posv_q[s];
    end
    for (int s = 1; s < 7; s++) begin
      k0_q[s+1] <= k0_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:0], req_i.valid};
    end
  end

  assign rsp_o.valid    = v_q[8];
  assign rsp_o.in_range = idx9_q < limit_q;
  assign rsp_o.idx      = idx9_q;

endmodule

FILE: rtl/hlva_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough accumulator back end
// Holds the vote store, sequences votes, reads and clears, and drives results.
// ----------------------------------------------------------------------------
`include "hough_line_vote_accumulator_top_defines.svh"

module hlva_back #(
  parameter int unsigned MAX_HALF_RADIUS = 512,
  parameter int unsigned COUNT_WIDTH     = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hlva_pkg::q_head_t      head_i,
  output hlva_pkg::bk_stat_t     stat_o,
  input  logic [9:0]             h_i,
  input  logic [8:0]             frac_i,
  output hlva_pkg::rad_req_t     req_o,
  input  hlva_pkg::rad_rsp_t     rsp_i,
  output logic [9:0]             a_o,
  output logic [9:0]             b_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [COUNT_WIDTH-1:0] peak_o
);

  localparam int unsigned DEPTH = hlva_pkg::ANGLE_BINS * 2 * MAX_HALF_RADIUS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned IW    = hlva_pkg::IDX_W;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_VOTE   = 3'd2;
  localparam logic [2:0] S_UNMARK = 3'd3;
  localparam logic [2:0] S_RIDX   = 3'd4;
  localparam logic [2:0] S_RMEM   = 3'd5;
  localparam logic [2:0] S_RCMP   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [CW-1:0] cnt_mem  [DEPTH];
  logic          mark_mem [DEPTH];
  logic [IW-1:0] list_mem [hlva_pkg::ANGLE_BINS];

  logic [2:0]    state_q;
  logic          init_q;
  logic [AW-1:0] clr_addr_q;
  logic [CW-1:0] peak_q;
  logic [7:0]    k_q, recv_q, n_q, j_q;
  logic          ph_q, rmw_q, um_v_q;
  logic          out_valid_q;

  hlva_pkg::item_t item_q;
  logic [AW-1:0]   rmw_addr_q;
  logic [IW-1:0]   ridx_q, list_rd_q;
  logic [CW-1:0]   cnt_rd_q, res_count_q, out_count_q, out_peak_q;
  logic            mark_rd_q;

  logic          pop, rmw_rd, cnt_we, mark_we, mark_wd, um_rd;
  logic [AW-1:0] cnt_raddr, cnt_waddr, mark_waddr;
  logic [CW-1:0] cnt_wd, inc;
  logic          below;

  always_comb begin
    pop         = (state_q == S_IDLE) && !init_q && head_i.valid;
    req_o.valid = (state_q == S_VOTE) && !ph_q && (k_q < 8'(hlva_pkg::ANGLE_BINS));
    req_o.k     = k_q;
    rmw_rd      = (state_q == S_VOTE) && rsp_i.valid && rsp_i.in_range;
    um_rd       = (state_q == S_UNMARK) && (j_q < n_q);
    inc         = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + CW'(1);
    cnt_raddr   = (state_q == S_VOTE) ? AW'(rsp_i.idx) : AW'(ridx_q);
    below       = ({1'b0, cnt_rd_q, 8'd0} < (CW+9)'(peak_q) * (CW+9)'(frac_i));
    cnt_we      = 1'b0;
    cnt_waddr   = clr_addr_q;
    cnt_wd      = '0;
    mark_we     = 1'b0;
    mark_waddr  = clr_addr_q;
    mark_wd     = 1'b0;
    if (state_q == S_CLR) begin
      cnt_we  = 1'b1;
      mark_we = 1'b1;
    end else if (rmw_q && !mark_rd_q) begin
      cnt_we     = 1'b1;
      cnt_waddr  = rmw_addr_q;
      cnt_wd     = inc;
      mark_we    = 1'b1;
      mark_waddr = rmw_addr_q;
      mark_wd    = 1'b1;
    end else if (um_v_q) begin
      mark_we    = 1'b1;
      mark_waddr = AW'(list_rd_q);
    end
  end

  assign stat_o.init = init_q;
  assign stat_o.pop  = pop;
  assign a_o         = item_q.a;
  assign b_o         = item_q.b;
  assign out_valid_o = out_valid_q;
  assign count_o     = out_count_q;
  assign peak_o      = out_peak_q;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wd;
    end
    mark_rd_q <= mark_mem[AW'(rsp_i.idx)];
  end

  always_ff @(posedge clk_i) begin
    if (rmw_rd) begin
      list_mem[n_q] <= rsp_i.idx;
    end
    if (um_rd) begin
      list_rd_q <= list_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q      <= head_i.item;
      res_count_q <= '0;
    end
    if (rmw_rd) begin
      rmw_addr_q <= AW'(rsp_i.idx);
    end
    if (state_q == S_RIDX) begin
      ridx_q <= IW'(item_q.angle) * IW'({h_i, 1'b0}) + IW'(item_q.radius);
    end
    if (state_q == S_RCMP) begin
      res_count_q <= (item_q.read_ok && !below) ? cnt_rd_q : '0;
    end
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      out_count_q <= res_count_q;
      out_peak_q  <= peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      clr_addr_q  <= '0;
      peak_q      <= '0;
      k_q         <= '0;
      recv_q      <= '0;
      n_q         <= '0;
      j_q         <= '0;
      ph_q        <= 1'b0;
      rmw_q       <= 1'b0;
      um_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rmw_q <= rmw_rd;
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            clr_addr_q <= '0;
            init_q     <= 1'b0;
            state_q    <= init_q ? S_IDLE : S_DONE;
          end else begin
            clr_addr_q <= clr_addr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (pop) begin
            case (head_i.item.op)
              hlva_pkg::OP_VOTE: begin
                k_q     <= '0;
                ph_q    <= 1'b0;
                recv_q  <= '0;
                n_q     <= '0;
                state_q <= S_VOTE;
              end
              hlva_pkg::OP_READ: state_q <= S_RIDX;
              hlva_pkg::OP_CLEAR: begin
                peak_q     <= '0;
                clr_addr_q <= '0;
                state_q    <= S_CLR;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_VOTE: begin
          ph_q <= !ph_q;
          if (req_o.valid) begin
            k_q <= k_q + 8'd1;
          end
          if (rsp_i.valid) begin
            recv_q <= recv_q + 8'd1;
          end
          if (rmw_rd) begin
            n_q <= n_q + 8'd1;
          end
          if (rmw_q && !mark_rd_q && (inc > peak_q)) begin
            peak_q <= inc;
          end
          if ((recv_q == 8'(hlva_pkg::ANGLE_BINS)) && !rmw_q && !rsp_i.valid) begin
            j_q     <= '0;
            um_v_q  <= 1'b0;
            state_q <= S_UNMARK;
          end
        end
        S_UNMARK: begin
          um_v_q <= um_rd;
          if (um_rd) begin
            j_q <= j_q + 8'd1;
          end
          if ((j_q == n_q) && !um_v_q) begin
            state_q <= S_DONE;
          end
        end
        S_RIDX: state_q <= S_RMEM;
        S_RMEM: state_q <= S_RCMP;
        S_RCMP: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `HLVA_ASSERT(a_rsp_only_in_vote, rsp_i.valid |-> state_q == S_VOTE, "index outside a vote")
  `HLVA_ASSERT(a_list_bound, n_q <= 8'(hlva_pkg::ANGLE_BINS), "cell list overflow")
  `HLVA_ASSERT(a_no_pop_in_init, init_q |-> !pop, "item taken during the clearing pass")
  `HLVA_ASSERT(a_rmw_follows_read, rmw_q |-> $past(rmw_rd), "write without matching read")
  `HLVA_ASSERT_ALWAYS(a_peak_reset, !rst_ni |-> peak_q == '0, "peak not cleared in reset")

endmodule

FILE: rtl/hough_line_vote_accumulator_top.sv
`timescale 1ns / 1ps
// A vote sends the 180 angles through the index pipeline and does a read-modify-write
// of the vote store for each in-range cell it reaches.
// A clear writes all 360*MAX_HALF_RADIUS store entries, one store entry per cycle.
// After reset the store is cleared the same way and no input transfer is taken until
// that pass ends; configuration writes are taken at once.
// ----------------------------------------------------------------------------
// Hough line vote accumulator
// Top level: configuration registers, front queue, index pipeline and vote store.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator_top #(
  parameter int unsigned MAX_HALF_RADIUS = 512,
  parameter int unsigned COUNT_WIDTH     = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [9:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [8:0]             row_i,
  input  logic [8:0]             column_i,
  input  logic                   edge_req_i,
  input  logic [7:0]             angle_bin_i,
  input  logic [9:0]             radius_bin_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [COUNT_WIDTH-1:0] peak_o
);

  localparam int unsigned HCAP = (MAX_HALF_RADIUS > 1023) ? 1023 : MAX_HALF_RADIUS;

  logic [9:0] half_radius_q;
  logic [8:0] thr_q;
  logic [9:0] h_eff, a, b;
  logic [8:0] frac_eff;

  hlva_pkg::q_head_t  head;
  hlva_pkg::bk_stat_t stat;
  hlva_pkg::rad_req_t req;
  hlva_pkg::rad_rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_radius_q <= 10'd512;
      thr_q         <= 9'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hlva_pkg::CFG_HALF_RADIUS: half_radius_q <= cfg_wdata_i;
        hlva_pkg::CFG_THRESHOLD:   thr_q         <= cfg_wdata_i[8:0];
        default:                   thr_q         <= thr_q;
      endcase
    end
  end

  assign h_eff    = (half_radius_q > 10'(HCAP)) ? 10'(HCAP) : half_radius_q;
  assign frac_eff = (thr_q > 9'd256) ? 9'd256 : thr_q;

  hlva_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .edge_req_i   (edge_req_i),
    .angle_bin_i  (angle_bin_i),
    .radius_bin_i (radius_bin_i),
    .h_i          (h_eff),
    .stat_i       (stat),
    .head_o       (head)
  );

  hlva_radius u_radius (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (a),
    .b_i    (b),
    .h_i    (h_eff),
    .rsp_o  (rsp)
  );

  hlva_back #(
    .MAX_HALF_RADIUS (MAX_HALF_RADIUS),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_o      (stat),
    .h_i         (h_eff),
    .frac_i      (frac_eff),
    .req_o       (req),
    .rsp_i       (rsp),
    .a_o         (a),
    .b_o         (b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .count_o     (count_o),
    .peak_o      (peak_o)
  );

endmodule

FILE: bench/tb_hough_line_vote_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough line vote accumulator testbench
// Drives vote, read, clear and unused requests through the valid/ready input
// channel, predicts every count and peak with a behavioural model of the
// accumulator, and compares each output transfer in order, with random idling
// on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_hough_line_vote_accumulator_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned MODEL_DEPTH = 180 * 2 * 512;
  localparam longint unsigned NANO = 64'd1000000000;

  localparam int unsigned SIN_NANO [0:90] = '{
    0, 17452406, 34899497, 52335956, 69756474, 87155743,
    104528463, 121869343, 139173101, 156434465, 173648178,
    190808995, 207911691, 224951054, 241921896, 258819045,
    275637356, 292371705, 309016994, 325568154, 342020143,
    358367950, 374606593, 390731128, 406736643, 422618262,
    438371147, 453990500, 469471563, 484809620, 500000000,
    515038075, 529919264, 544639035, 559192903, 573576436,
    587785252, 601815023, 615661475, 629320391, 642787610,
    656059029, 669130606, 681998360, 694658370, 707106781,
    719339800, 731353702, 743144825, 754709580, 766044443,
    777145961, 788010754, 798635510, 809016994, 819152044,
    829037573, 838670568, 848048096, 857167301, 866025404,
    874619707, 882947593, 891006524, 898794046, 906307787,
    913545458, 920504853, 927183855, 933580426, 939692621,
    945518576, 951056516, 956304756, 961261696, 965925826,
    970295726, 974370065, 978147601, 981627183, 984807753,
    987688341, 990268069, 992546152, 994521895, 996194698,
    997564050, 998629535, 999390827, 999847695, 1000000000
  };

  typedef struct {
    logic [15:0] count;
    logic [15:0] peak;
  } vote_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [9:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [8:0]  row_i;
  logic [8:0]  column_i;
  logic        edge_req_i;
  logic [7:0]  angle_bin_i;
  logic [9:0]  radius_bin_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] count_o;
  logic [15:0] peak_o;

  logic [15:0] vote_model [0:MODEL_DEPTH-1];
  logic [15:0] peak_model;
  logic [9:0]  half_radius_reg;
  logic [8:0]  fraction_reg;
  vote_result_t pending_results [$];
  logic [8:0]  pixel_rows [$];
  logic [8:0]  pixel_cols [$];
  int          error_count;
  bit          send_burst;
  bit          accept_burst;

  hough_line_vote_accumulator_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .edge_req_i   (edge_req_i),
    .angle_bin_i  (angle_bin_i),
    .radius_bin_i (radius_bin_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .count_o      (count_o),
    .peak_o       (peak_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("hough_line_vote_accumulator_top verification failed");
    $finish;
  end

  function automatic longint unsigned active_half();
    return (half_radius_reg > 10'd512) ? 64'd512 : longint'(half_radius_reg);
  endfunction

  function automatic longint unsigned line_radius(int unsigned k, longint unsigned a,
                                                  longint unsigned b);
    longint unsigned pos, neg, mag, r;
    bit positive;
    if (k == 0) return a;
    if (k <= 90) begin
      pos = b * SIN_NANO[k] + a * SIN_NANO[90 - k];
      neg = 0;
    end else begin
      pos = b * SIN_NANO[180 - k];
      neg = a * SIN_NANO[k - 90];
    end
    positive = pos > neg;
    mag = (pos >= neg) ? pos - neg : neg - pos;
    r = (mag + NANO / 2) / NANO;
    if (positive) r += active_half();
    return r;
  endfunction

  function automatic void cast_pixel_votes(logic [8:0] row, logic [8:0] col);
    longint unsigned h, a, b, idx;
    bit cell_hit [longint unsigned];
    h = active_half();
    a = longint'(row) + 1;
    b = longint'(col) + 1;
    for (int unsigned k = 0; k < 180; k++) begin
      idx = longint'(k) * 2 * h + line_radius(k, a, b);
      if (idx < 360 * h && idx < MODEL_DEPTH && !cell_hit.exists(idx)) begin
        cell_hit[idx] = 1'b1;
        if (vote_model[idx] != 16'hFFFF) vote_model[idx] = vote_model[idx] + 16'd1;
        if (vote_model[idx] > peak_model) peak_model = vote_model[idx];
      end
    end
  endfunction

  function automatic logic [15:0] thresholded_count(logic [7:0] ang, logic [9:0] rad);
    longint unsigned h, idx, frac;
    h = active_half();
    if (ang >= 8'd180 || longint'(rad) >= 2 * h) return 16'd0;
    idx = longint'(ang) * 2 * h + rad;
    if (idx >= MODEL_DEPTH) return 16'd0;
    frac = (fraction_reg > 9'd256) ? 64'd256 : longint'(fraction_reg);
    if (longint'(vote_model[idx]) * 256 < longint'(peak_model) * frac) return 16'd0;
    return vote_model[idx];
  endfunction

  function automatic void clear_vote_model();
    for (int unsigned i = 0; i < MODEL_DEPTH; i++) vote_model[i] = 16'd0;
    peak_model = 16'd0;
  endfunction

  function automatic vote_result_t predict_transfer(logic [1:0] kind, logic [8:0] row,
                                                    logic [8:0] col, logic edge_bit,
                                                    logic [7:0] ang, logic [9:0] rad);
    vote_result_t res;
    res.count = 16'd0;
    case (kind)
      hlva_pkg::KIND_VOTE: begin
        if (edge_bit) cast_pixel_votes(row, col);
      end
      hlva_pkg::KIND_READ: begin
        res.count = thresholded_count(ang, rad);
      end
      hlva_pkg::KIND_CLEAR: begin
        clear_vote_model();
      end
      default: begin
      end
    endcase
    res.peak = peak_model;
    return res;
  endfunction

  task automatic send_request(logic [1:0] kind, logic [8:0] row, logic [8:0] col,
                              logic edge_bit, logic [7:0] ang, logic [9:0] rad);
    int gap;
    bit taken;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    row_i        <= row;
    column_i     <= col;
    edge_req_i   <= edge_bit;
    angle_bin_i  <= ang;
    radius_bin_i <= rad;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(predict_transfer(kind, row, col, edge_bit, ang, rad));
    if (kind == hlva_pkg::KIND_VOTE && edge_bit) begin
      pixel_rows.push_back(row);
      pixel_cols.push_back(col);
      if (pixel_rows.size() > 16) begin
        void'(pixel_rows.pop_front());
        void'(pixel_cols.pop_front());
      end
    end
  endtask

  task automatic send_vote(logic [8:0] row, logic [8:0] col);
    send_request(hlva_pkg::KIND_VOTE, row, col, 1'b1, 8'($urandom), 10'($urandom));
  endtask

  task automatic send_read(logic [7:0] ang, logic [9:0] rad);
    send_request(hlva_pkg::KIND_READ, 9'($urandom), 9'($urandom), 1'($urandom), ang, rad);
  endtask

  // Reads a cell that one of the recent pixels voted for at a random angle.
  task automatic send_voted_read();
    int unsigned p, k;
    longint unsigned r;
    if (pixel_rows.size() == 0) begin
      send_read(8'($urandom_range(0, 179)), 10'($urandom));
    end else begin
      p = $urandom_range(0, pixel_rows.size() - 1);
      k = $urandom_range(0, 179);
      r = line_radius(k, longint'(pixel_rows[p]) + 1, longint'(pixel_cols[p]) + 1);
      send_read(k[7:0], r[9:0]);
    end
  endtask

  task automatic send_random(logic [1:0] kind);
    send_request(kind, 9'($urandom), 9'($urandom), 1'($urandom), 8'($urandom),
                 10'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(logic index, logic [9:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == hlva_pkg::CFG_HALF_RADIUS) half_radius_reg = value;
    else fraction_reg = value[8:0];
    @(posedge clk_i);
  endtask

  initial begin
    int gap;
    bit taken;
    vote_result_t seen;
    vote_result_t want;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = accept_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        seen.count = count_o;
        seen.peak = peak_o;
        @(posedge clk_i);
      end while (!taken);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result count=%0d peak=%0d", $time, seen.count, seen.peak);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (seen.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, seen.count);
          error_count++;
        end
        if (seen.peak !== want.peak) begin
          $display("%0t: peak expected %0d actual %0d", $time, want.peak, seen.peak);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_read(8'd0, 10'd0);
    send_read(8'd179, 10'd1023);
    send_request(KIND_UNUSED, 9'h1FF, 9'h1FF, 1'b1, 8'hFF, 10'h3FF);
    send_request(hlva_pkg::KIND_VOTE, 9'd100, 9'd200, 1'b0, 8'd0, 10'd0);
  endtask

  task automatic test_directed_votes();
    send_vote(9'd0, 9'd0);
    send_vote(9'd511, 9'd511);
    send_vote(9'd0, 9'd511);
    send_vote(9'd511, 9'd0);
    repeat (3) send_vote(9'd20, 9'd30);
    send_read(8'd0, 10'd21);
    send_read(8'd0, 10'd1);
    send_read(8'd90, 10'd512 + 10'd31);
    send_read(8'd180, 10'd21);
    send_read(8'd255, 10'd0);
    send_read(8'd45, 10'd1023);
    repeat (4) send_voted_read();
    send_request(KIND_UNUSED, 9'd0, 9'd0, 1'b0, 8'd0, 10'd0);
    send_random(hlva_pkg::KIND_CLEAR);
    send_read(8'd0, 10'd21);
    send_vote(9'd5, 9'd5);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_register(hlva_pkg::CFG_HALF_RADIUS, 10'd1);
    write_register(hlva_pkg::CFG_THRESHOLD, 10'd0);
    send_vote(9'd0, 9'd0);
    send_vote(9'd3, 9'd1);
    send_read(8'd0, 10'd1);
    send_read(8'd1, 10'd0);
    send_read(8'd0, 10'd2);
    wait_idle();
    write_register(hlva_pkg::CFG_HALF_RADIUS, 10'd0);
    write_register(hlva_pkg::CFG_THRESHOLD, 10'd256);
    send_vote(9'd7, 9'd9);
    send_read(8'd0, 10'd0);
    wait_idle();
    write_register(hlva_pkg::CFG_HALF_RADIUS, 10'd1023);
    write_register(hlva_pkg::CFG_THRESHOLD, 10'd511);
    send_vote(9'd7, 9'd9);
    send_vote(9'd7, 9'd9);
    repeat (3) send_voted_read();
    wait_idle();
  endtask

  task automatic run_random_phase(logic [9:0] half, logic [8:0] frac, int unsigned items,
                                  bit with_clear);
    logic [8:0] pool_row [0:7];
    logic [8:0] pool_col [0:7];
    int unsigned pick;
    write_register(hlva_pkg::CFG_HALF_RADIUS, half);
    write_register(hlva_pkg::CFG_THRESHOLD, {1'b0, frac});
    for (int i = 0; i < 8; i++) begin
      pool_row[i] = 9'($urandom);
      pool_col[i] = 9'($urandom);
    end
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        accept_burst = ($urandom_range(0, 3) == 0);
      end
      if (with_clear && n == items / 2) begin
        send_random(hlva_pkg::KIND_CLEAR);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) send_vote(pool_row[$urandom_range(0, 7)], pool_col[$urandom_range(0, 7)]);
      else if (pick < 55) send_vote(9'($urandom), 9'($urandom));
      else if (pick < 60) send_request(hlva_pkg::KIND_VOTE, 9'($urandom), 9'($urandom), 1'b0,
                                       8'($urandom), 10'($urandom));
      else if (pick < 80) send_voted_read();
      else if (pick < 97) send_read(8'($urandom), 10'($urandom));
      else send_random(KIND_UNUSED);
    end
    send_burst = 1'b0;
    accept_burst = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(10'd512, 9'd128, 200, 1'b0);
    run_random_phase(10'd37, 9'd256, 180, 1'b1);
    run_random_phase(10'd1, 9'd0, 120, 1'b0);
    run_random_phase(10'd1023, 9'd511, 180, 1'b0);
    run_random_phase(10'd200, 9'd64, 200, 1'b1);
    run_random_phase(10'd0, 9'd200, 60, 1'b0);
    run_random_phase(10'd300, 9'd192, 160, 1'b0);
  endtask

  initial begin
    error_count = 0;
    send_burst = 1'b0;
    accept_burst = 1'b0;
    half_radius_reg = 10'd512;
    fraction_reg = 9'd128;
    clear_vote_model();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= 1'b0;
    cfg_wdata_i  <= 10'd0;
    in_valid_i   <= 1'b0;
    kind_i       <= hlva_pkg::KIND_VOTE;
    row_i        <= 9'd0;
    column_i     <= 9'd0;
    edge_req_i   <= 1'b0;
    angle_bin_i  <= 8'd0;
    radius_bin_i <= 10'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_votes();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("hough_line_vote_accumulator_top verification clean");
    end else begin
      $display("hough_line_vote_accumulator_top verification failed");
    end
    $finish;
  end

endmodule
